// File: rtl/core/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, constants and control types of the modular exponentiation
// core (modulus 1000000007).
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int BASE_W = 31;
  localparam int EXP_W  = 31;
  localparam int RES_W  = 30;

  // exponent bits that are scanned; higher bits count as zero
  localparam int EXP_BITS = 31;

  localparam logic [EXP_W-1:0] EXP_MASK =
    (EXP_BITS >= EXP_W) ? {EXP_W{1'b1}} : EXP_W'((64'd1 << EXP_BITS) - 64'd1);

  localparam logic [RES_W-1:0]  MODULUS   = RES_W'(1000000007);
  localparam logic [BASE_W-1:0] MODULUS_2 = BASE_W'(2000000014);
  localparam logic [RES_W-1:0]  ONE       = RES_W'(1);

  // Barrett: k = 30, q1 = x >> 29, mu = floor(2^60 / p), q = (q1 * mu) >> 31
  localparam int          BAR_K = 30;
  localparam logic [30:0] MU    = 31'(64'h1000_0000_0000_0000 / 64'd1000000007);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_MUL_WAIT,
    ST_SQR,
    ST_SQR_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;     // capture base / exponent
    logic mm_start; // launch modular multiply
    logic sel_sqr;  // operands sq*sq instead of acc*sq
    logic acc_wr;   // write multiplier result to acc
    logic sq_wr;    // write multiplier result to sq, shift exponent
  } cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic exp_lsb;
    logic exp_last; // no set bit above the lsb
    logic mm_done;
  } status_t;

endpackage

// File: rtl/core/mexp_modmul.sv
// ----------------------------------------------------------------------------
// mexp_modmul
// Pipelined a*b mod p by Barrett reduction; done flags a valid result.
// ----------------------------------------------------------------------------
module mexp_modmul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [mexp_pkg::RES_W-1:0] op_a,
  input  logic [mexp_pkg::RES_W-1:0] op_b,
  output logic                       done,
  output logic [mexp_pkg::RES_W-1:0] result
);

  logic [3:0]  vld_r;
  logic [59:0] prod_r;
  logic [59:0] prod2_r;
  logic [59:0] prod3_r;
  logic [61:0] t_r;
  logic [60:0] qp_r;
  logic [31:0] rem_r;
  logic [60:0] diff;
  logic [31:0] rem_p2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], start};
    end
  end

  assign diff = {1'b0, prod3_r} - qp_r;

  always_ff @(posedge clk) begin
    prod_r  <= {30'd0, op_a} * {30'd0, op_b};
    t_r     <= {31'd0, prod_r[59:mexp_pkg::BAR_K-1]} * {31'd0, mexp_pkg::MU};
    prod2_r <= prod_r;
    qp_r    <= {30'd0, t_r[61:31]} * {31'd0, mexp_pkg::MODULUS};
    prod3_r <= prod2_r;
    rem_r   <= diff[31:0]; // below 3p
  end

  assign rem_p2 = {1'b0, mexp_pkg::MODULUS_2};

  always_comb begin
    if (rem_r >= rem_p2) begin
      result = mexp_pkg::RES_W'(rem_r - rem_p2);
    end else if (rem_r >= {2'b00, mexp_pkg::MODULUS}) begin
      result = mexp_pkg::RES_W'(rem_r - {2'b00, mexp_pkg::MODULUS});
    end else begin
      result = rem_r[mexp_pkg::RES_W-1:0];
    end
  end

  assign done = vld_r[3];

endmodule

// File: rtl/core/mexp_datapath.sv
// ----------------------------------------------------------------------------
// mexp_datapath
// Accumulator, running square and exponent registers around the shared
// modular multiplier.
// ----------------------------------------------------------------------------
module mexp_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mexp_pkg::cmd_t              cmd,
  output mexp_pkg::status_t           sts,
  input  logic [mexp_pkg::BASE_W-1:0] base,
  input  logic [mexp_pkg::EXP_W-1:0]  exponent,
  output logic [mexp_pkg::RES_W-1:0]  residue
);

  logic [mexp_pkg::RES_W-1:0] acc_r, acc_nxt;
  logic [mexp_pkg::RES_W-1:0] sq_r, sq_nxt;
  logic [mexp_pkg::EXP_W-1:0] exp_r, exp_nxt;
  logic [mexp_pkg::RES_W-1:0] base_red;
  logic [mexp_pkg::RES_W-1:0] mm_a;
  logic [mexp_pkg::RES_W-1:0] mm_res;
  logic                       mm_done;

  // base < 2^31 < 3p
  always_comb begin
    if (base >= mexp_pkg::MODULUS_2) begin
      base_red = mexp_pkg::RES_W'(base - mexp_pkg::MODULUS_2);
    end else if (base >= {1'b0, mexp_pkg::MODULUS}) begin
      base_red = mexp_pkg::RES_W'(base - {1'b0, mexp_pkg::MODULUS});
    end else begin
      base_red = base[mexp_pkg::RES_W-1:0];
    end
  end

  assign mm_a = cmd.sel_sqr ? sq_r : acc_r;

  mexp_modmul u_modmul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.mm_start),
    .op_a   (mm_a),
    .op_b   (sq_r),
    .done   (mm_done),
    .result (mm_res)
  );

  always_comb begin
    acc_nxt = acc_r;
    sq_nxt  = sq_r;
    exp_nxt = exp_r;
    if (cmd.load) begin
      acc_nxt = mexp_pkg::ONE;
      sq_nxt  = base_red;
      exp_nxt = exponent & mexp_pkg::EXP_MASK;
    end else begin
      if (cmd.acc_wr) begin
        acc_nxt = mm_res;
      end
      if (cmd.sq_wr) begin
        sq_nxt  = mm_res;
        exp_nxt = exp_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    sq_r  <= sq_nxt;
    exp_r <= exp_nxt;
  end

  assign sts.exp_zero = (exp_r == '0);
  assign sts.exp_lsb  = exp_r[0];
  assign sts.exp_last = (exp_r[mexp_pkg::EXP_W-1:1] == '0);
  assign sts.mm_done  = mm_done;
  assign residue      = acc_r;

endmodule

// File: rtl/core/mexp_ctrl.sv
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer for right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
module mexp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  mexp_pkg::status_t sts,
  output mexp_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              out_valid
);

  mexp_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mexp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mexp_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = mexp_pkg::ST_CHECK;
        end
      end
      mexp_pkg::ST_CHECK: begin
        if (sts.exp_zero) begin
          state_nxt = mexp_pkg::ST_DONE;
        end else if (sts.exp_lsb) begin
          state_nxt = mexp_pkg::ST_MUL;
        end else begin
          state_nxt = mexp_pkg::ST_SQR;
        end
      end
      mexp_pkg::ST_MUL:      state_nxt = mexp_pkg::ST_MUL_WAIT;
      mexp_pkg::ST_MUL_WAIT: begin
        if (sts.mm_done) begin
          // skip the square after the top set bit
          state_nxt = sts.exp_last ? mexp_pkg::ST_DONE : mexp_pkg::ST_SQR;
        end
      end
      mexp_pkg::ST_SQR:      state_nxt = mexp_pkg::ST_SQR_WAIT;
      mexp_pkg::ST_SQR_WAIT: begin
        if (sts.mm_done) begin
          state_nxt = mexp_pkg::ST_CHECK;
        end
      end
      mexp_pkg::ST_DONE:     state_nxt = mexp_pkg::ST_IDLE;
      default:               state_nxt = mexp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      mexp_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      mexp_pkg::ST_MUL:      cmd.mm_start = 1'b1;
      mexp_pkg::ST_MUL_WAIT: cmd.acc_wr = sts.mm_done;
      mexp_pkg::ST_SQR: begin
        cmd.mm_start = 1'b1;
        cmd.sel_sqr  = 1'b1;
      end
      mexp_pkg::ST_SQR_WAIT: cmd.sq_wr = sts.mm_done;
      mexp_pkg::ST_DONE:     out_valid = 1'b1;
      default:               cmd = '0;
    endcase
  end

endmodule

// File: rtl/core/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// base^exponent mod 1000000007 by right-to-left square-and-multiply on one
// pipelined Barrett modular multiplier.
// ----------------------------------------------------------------------------
//
//  channel   ports                           handshake
//  --------  ------------------------------  --------------------------------
//  input     in_base[30:0], in_exponent[30:0] taken when start && !busy
//  result    out_residue[29:0]               out_valid, one cycle, no stall
//
// Sequencing: one transaction at a time. Each set exponent bit costs one
//   multiply and each bit below the top set bit one square; a zero exponent
//   goes from the check straight to the out_valid state. Each multiply or
//   square is one pass through the four-stage modular multiplier.
// Reset: rst_n is synchronous; it returns the sequencer to idle and clears
//   the multiplier's valid pipe. Data registers are not reset.
// Stalls: busy stays high from acceptance through the out_valid cycle; the
//   receiver must take the result in that cycle.
// ----------------------------------------------------------------------------
module modular_exponentiation (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [mexp_pkg::BASE_W-1:0] in_base,
  input  logic [mexp_pkg::EXP_W-1:0]  in_exponent,
  output logic                        out_valid,
  output logic [mexp_pkg::RES_W-1:0]  out_residue
);

  // command / status between sequencer and datapath
  mexp_pkg::cmd_t    cmd;
  mexp_pkg::status_t sts;

  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // acc / sq / exponent registers and the modular multiplier
  mexp_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .base     (in_base),
    .exponent (in_exponent),
    .residue  (out_residue)
  );

endmodule

// File: rtl/core/mexp_checker.sv
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks on the modular exponentiation core.
// ----------------------------------------------------------------------------
module mexp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [mexp_pkg::EXP_W-1:0]  in_exponent,
  input logic                        out_valid,
  input logic [mexp_pkg::RES_W-1:0]  out_residue
);

  // accepted transaction keeps the core busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("core not busy after accepting a transaction");

  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_residue < mexp_pkg::MODULUS))
    else $error("residue not reduced");

  // zero exponent gives 1 on the fast path
  a_zero_exp: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_exponent == '0) |-> ##2 (out_valid && out_residue == mexp_pkg::ONE))
    else $error("zero exponent did not give 1");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_exponent (in_exponent),
  .out_valid   (out_valid),
  .out_residue (out_residue)
);

// File: bench/tb_modular_exponentiation.sv
// ----------------------------------------------------------------------------
// tb_modular_exponentiation
// Self-checking bench for the modulo-1000000007 exponentiation core: directed
// corner transactions, then about a thousand random ones, each result checked
// in order against a bit-accurate square-and-multiply predictor.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation;

  localparam int          BASE_W      = mexp_pkg::BASE_W;
  localparam int          EXP_W       = mexp_pkg::EXP_W;
  localparam int          RES_W       = mexp_pkg::RES_W;
  localparam int          EXP_BITS    = mexp_pkg::EXP_BITS;
  localparam logic [BASE_W-1:0] MODULUS_2 = mexp_pkg::MODULUS_2;

  localparam bit [63:0]   PRIME       = 64'd1000000007;
  localparam int          RAND_JOBS   = 1030;
  localparam int          DRAIN_EVERY = 150;   // sender waits for an empty pipe
  localparam int          TAIL_CYCLES = 400;   // idle run after the last residue
  localparam int          STALL_LIMIT = 4000;  // cycles with no transaction
  localparam logic [BASE_W-1:0] BASE_MAX = {BASE_W{1'b1}};
  localparam logic [EXP_W-1:0]  EXP_MAX  = {EXP_W{1'b1}};

  typedef struct {
    logic [BASE_W-1:0] base;
    logic [EXP_W-1:0]  exponent;
    bit                drain;   // hold off until every residue is back
  } job_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [BASE_W-1:0] in_base;
  logic [EXP_W-1:0]  in_exponent;
  logic              out_valid;
  logic [RES_W-1:0]  out_residue;

  job_t              jobs_pending[$];
  logic [RES_W-1:0]  residues_due[$];

  bit                took_job;      // set at posedge, read by the driver at negedge
  int                idle_left;
  int                idle_cycles;
  int                mismatch_count;
  int                jobs_done;
  int                zero_exp_jobs;
  int                prime_mult_jobs;
  int                wide_exp_jobs;

  modular_exponentiation u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_base     (in_base),
    .in_exponent (in_exponent),
    .out_valid   (out_valid),
    .out_residue (out_residue)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Right-to-left square-and-multiply over the scanned exponent bits.
  // Both operands stay below 2^30, so 64-bit products never overflow.
  function automatic logic [RES_W-1:0] power_mod_prime(logic [BASE_W-1:0] b,
                                                       logic [EXP_W-1:0] e);
    bit [63:0] acc;
    bit [63:0] sq;
    acc = 64'd1;
    sq  = 64'(b) % PRIME;
    for (int i = 0; i < EXP_BITS && i < 63; i++) begin
      if (i < EXP_W && e[i]) acc = (acc * sq) % PRIME;
      sq = (sq * sq) % PRIME;
    end
    return RES_W'(acc);
  endfunction

  // Mostly back-to-back, sometimes a short gap, rarely one long enough to land
  // anywhere inside a full-length exponentiation.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55)      return 0;
    else if (roll < 85) return $urandom_range(1, 3);
    else if (roll < 96) return $urandom_range(4, 20);
    else                return $urandom_range(21, 400);
  endfunction

  function automatic logic [BASE_W-1:0] pick_base();
    bit [63:0] near;
    case ($urandom_range(0, 9))
      0: return BASE_W'($urandom_range(0, 3));
      1: begin
        // k*p - 1, k*p, k*p + 1 for k = 1, 2; 2p + 1 still fits in 31 bits
        near = PRIME * $urandom_range(1, 2) + $urandom_range(0, 2) - 64'd1;
        return BASE_W'(near);
      end
      2: return BASE_MAX - BASE_W'($urandom_range(0, 3));
      default: return BASE_W'($urandom);
    endcase
  endfunction

  function automatic logic [EXP_W-1:0] pick_exponent();
    int        n;
    bit [31:0] mask;
    n    = $urandom_range(1, EXP_W);
    mask = (32'd1 << n) - 32'd1;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return EXP_W'(PRIME - 64'd2);           // Fermat inverse
      2: return EXP_W'(32'd1 << $urandom_range(0, EXP_W - 1));
      3: return EXP_W'(mask);                    // all ones up to bit n-1
      default: return EXP_W'($urandom & mask);
    endcase
  endfunction

  task automatic add_job(logic [BASE_W-1:0] b, logic [EXP_W-1:0] e, bit drain);
    job_t job;
    job.base     = b;
    job.exponent = e;
    job.drain    = drain;
    jobs_pending.insert(jobs_pending.size(), job);
  endtask

  // --------------------------------------------------------------------------
  // Driver: changes inputs on the falling edge. start stays high until the
  // transaction is taken (start && !busy at a rising edge), then an optional
  // idle gap follows. A job flagged drain is not offered while any residue
  // is still outstanding.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : stim_driver
    job_t job;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took_job) begin
      if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start     <= 1'b0;
      end else if (jobs_pending.size() != 0 &&
                   (!jobs_pending[0].drain || residues_due.size() == 0)) begin
        job          = jobs_pending.pop_front();
        in_base     <= job.base;
        in_exponent <= job.exponent;
        start       <= 1'b1;
        idle_left   <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: samples on the rising edge. Every accepted transaction queues its
  // predicted residue; every out_valid pops and compares the oldest one.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    logic [RES_W-1:0] want;
    bit               active;
    took_job = 1'b0;
    active   = 1'b0;
    if (rst_n) begin
      if (start && !busy) begin
        took_job = 1'b1;
        active   = 1'b1;
        residues_due.insert(residues_due.size(),
                            power_mod_prime(in_base, in_exponent));
        jobs_done++;
        if (in_exponent == '0) zero_exp_jobs++;
        if ((64'(in_base) % PRIME) == 64'd0) prime_mult_jobs++;
        if (in_exponent[EXP_W-1]) wide_exp_jobs++;
      end
      if (out_valid) begin
        active = 1'b1;
        if (residues_due.size() == 0) begin
          mismatch_count++;
          $display("[%0t] unexpected residue: expected none, actual %0d",
                   $time, out_residue);
        end else begin
          want = residues_due.pop_front();
          if (out_residue !== want) begin
            mismatch_count++;
            $display("[%0t] residue mismatch: expected %0d, actual %0d",
                     $time, want, out_residue);
          end
        end
      end
    end
    idle_cycles <= active ? 0 : idle_cycles + 1;
  end

  // Watchdog: a hung core or a dropped result stops all transactions.
  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("[%0t] no transaction for %0d cycles, %0d residues outstanding",
             $time, STALL_LIMIT, residues_due.size());
    $display("modular_exponentiation test failed");
    $finish;
  end

  initial begin : sequencer
    rst_n          = 1'b0;
    start          = 1'b0;
    in_base        = '0;
    in_exponent    = '0;
    took_job       = 1'b0;
    idle_left      = 0;
    idle_cycles    = 0;
    mismatch_count = 0;
    jobs_done      = 0;
    zero_exp_jobs  = 0;
    prime_mult_jobs = 0;
    wide_exp_jobs  = 0;

    // zero exponent, including zero and multiples of the prime as base
    add_job('0, '0, 1'b0);
    add_job(BASE_W'(1), '0, 1'b0);
    add_job(BASE_MAX, '0, 1'b0);
    add_job(BASE_W'(PRIME), '0, 1'b0);
    add_job(MODULUS_2, '0, 1'b0);
    // base a multiple of the prime with a nonzero exponent gives zero
    add_job(BASE_W'(PRIME), EXP_W'(5), 1'b0);
    add_job(MODULUS_2, EXP_MAX, 1'b0);
    add_job('0, EXP_W'(1), 1'b0);
    add_job('0, EXP_MAX, 1'b0);
    // field extremes
    add_job(BASE_MAX, EXP_MAX, 1'b0);
    add_job(BASE_MAX, EXP_W'(1), 1'b0);
    add_job(BASE_W'(1), EXP_MAX, 1'b0);
    add_job(BASE_MAX, EXP_W'(32'h4000_0000), 1'b0);
    // modular inverses and unreduced bases around the prime
    add_job(BASE_W'(2), EXP_W'(PRIME - 64'd2), 1'b1);
    add_job(BASE_W'(PRIME - 64'd1), EXP_W'(PRIME - 64'd2), 1'b0);
    add_job(BASE_W'(PRIME + 64'd1), EXP_W'(12345), 1'b0);
    add_job(BASE_W'(PRIME - 64'd1), EXP_W'(2), 1'b0);
    add_job(BASE_W'(2 * PRIME + 64'd1), EXP_W'(3), 1'b0);
    // alternating bit patterns
    add_job(BASE_W'(3), EXP_W'(32'h5555_5555), 1'b0);
    add_job(BASE_W'(32'h2AAA_AAAA), EXP_W'(32'h2AAA_AAAA), 1'b0);
    add_job(BASE_W'(32'h5555_5555), EXP_W'(32'h5555_5555), 1'b0);

    for (int i = 0; i < RAND_JOBS; i++)
      add_job(pick_base(), pick_exponent(), (i % DRAIN_EVERY) == DRAIN_EVERY - 1);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (jobs_pending.size() != 0 || start || residues_due.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d exponentiations: %0d zero exponents, %0d bases divisible by p,",
             jobs_done, zero_exp_jobs, prime_mult_jobs);
    $display("%0d exponents using bit 30; %0d mismatches.",
             wide_exp_jobs, mismatch_count);
    if (mismatch_count == 0 && residues_due.size() == 0) begin
      $display("modular_exponentiation test passed");
    end else begin
      $display("modular_exponentiation test failed");
    end
    $finish;
  end

endmodule
